// ----- design/didrp_pkg.sv -----
`default_nettype none

package didrp_pkg;

  // Frame layout
  localparam logic [3:0] POS_FUNC    = 4'd7;
  localparam logic [3:0] POS_TYPE    = 4'd8;
  localparam logic [3:0] POS_COUNT   = 4'd13;
  localparam logic [3:0] ENTRY_START = 4'd14;
  // Exception needs at least 9 bytes, i.e. byte index 8 reached
  localparam logic [3:0] MIN_EXC_POS = 4'd8;

  localparam logic [7:0] FC_DEVID  = 8'h2B;
  localparam logic [7:0] MEI_DEVID = 8'h0E;
  localparam logic [7:0] EXC_MASK  = 8'h80;

  typedef enum logic [2:0] {
    KIND_VALUE     = 3'd0,
    KIND_OBJECT    = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_NONE      = 3'd3,
    KIND_EXC       = 3'd4,
    KIND_MALFORMED = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_ID  = 3'b001,
    PH_LEN = 3'b010,
    PH_VAL = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] object_id;
    logic [7:0] object_length;
    logic [7:0] data_byte;
    logic [7:0] object_count;
    logic [7:0] exc_reason;
  } res_t;

  // Up to three results per byte, always in this order: value, object, final.
  // mask[0] = value, mask[1] = object complete, mask[2] = final.
  typedef struct packed {
    logic [2:0] mask;
    res_t       val;
    res_t       obj;
    res_t       fin;
  } bundle_t;

endpackage

`default_nettype wire

// ----- design/didrp_chan_if.sv -----
`default_nettype none

interface didrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] response_byte;
  logic       end_of_response;

  modport source (output valid, output response_byte, output end_of_response, input ready);
  modport sink   (input valid, input response_byte, input end_of_response, output ready);
endinterface

interface didrp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] object_id;
  logic [7:0] object_length;
  logic [7:0] data_byte;
  logic [7:0] object_count;
  logic [7:0] exc_reason;
  logic       last_of_run;

  modport source (output valid, output result_kind, output object_id, output object_length,
                  output data_byte, output object_count, output exc_reason,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input object_id, input object_length,
                  input data_byte, input object_count, input exc_reason,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/didrp_parser.sv -----
`default_nettype none

module didrp_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               acc,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               rx_eor,
  output didrp_pkg::bundle_t      bundle
);

  logic [3:0]         pos_r,      pos_nxt;
  logic [7:0]         fn_r,       fn_nxt;
  logic [7:0]         ty_r,       ty_nxt;
  didrp_pkg::phase_t  phase_r,    phase_nxt;
  logic [7:0]         left_r,     left_nxt;
  logic [7:0]         id_r,       id_nxt;
  logic [7:0]         len_r,      len_nxt;
  logic [7:0]         vleft_r,    vleft_nxt;
  logic [7:0]         complete_r, complete_nxt;

  logic hdr_ok;
  logic val_hit;
  logic obj_hit;

  assign hdr_ok = (fn_r == didrp_pkg::FC_DEVID) && (ty_r == didrp_pkg::MEI_DEVID);

  always_comb begin
    pos_nxt      = pos_r;
    fn_nxt       = fn_r;
    ty_nxt       = ty_r;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    vleft_nxt    = vleft_r;
    complete_nxt = complete_r;
    val_hit      = 1'b0;
    obj_hit      = 1'b0;

    if (pos_r == didrp_pkg::POS_FUNC) begin
      fn_nxt = rx_byte;
    end else if (pos_r == didrp_pkg::POS_TYPE) begin
      ty_nxt = rx_byte;
    end else if (pos_r == didrp_pkg::POS_COUNT) begin
      left_nxt  = rx_byte;
      phase_nxt = didrp_pkg::PH_ID;
    end else if (pos_r >= didrp_pkg::ENTRY_START && hdr_ok) begin
      case (phase_r)
        didrp_pkg::PH_ID: begin
          if (left_r != 8'd0) begin
            id_nxt    = rx_byte;
            phase_nxt = didrp_pkg::PH_LEN;
          end
        end
        didrp_pkg::PH_LEN: begin
          len_nxt   = rx_byte;
          vleft_nxt = rx_byte;
          if (rx_byte == 8'd0) begin
            obj_hit = 1'b1;
          end else begin
            phase_nxt = didrp_pkg::PH_VAL;
          end
        end
        didrp_pkg::PH_VAL: begin
          val_hit   = 1'b1;
          vleft_nxt = vleft_r - 8'd1;
          if (vleft_nxt == 8'd0) begin
            obj_hit = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (obj_hit) begin
      complete_nxt = complete_r + 8'd1;
      left_nxt     = left_r - 8'd1;
      phase_nxt    = didrp_pkg::PH_ID;
    end

    if (pos_r < didrp_pkg::ENTRY_START) begin
      pos_nxt = pos_r + 4'd1;
    end

    // result payloads, taken before the end-of-frame clear below
    bundle.mask = {rx_eor, obj_hit, val_hit};

    bundle.val                = '0;
    bundle.val.kind           = didrp_pkg::KIND_VALUE;
    bundle.val.object_id      = id_r;
    bundle.val.object_length  = len_r;
    bundle.val.data_byte      = rx_byte;

    bundle.obj                = '0;
    bundle.obj.kind           = didrp_pkg::KIND_OBJECT;
    bundle.obj.object_id      = id_nxt;
    bundle.obj.object_length  = len_nxt;

    bundle.fin = '0;
    if (pos_r >= didrp_pkg::MIN_EXC_POS && (fn_nxt & didrp_pkg::EXC_MASK) != 8'd0) begin
      bundle.fin.kind       = didrp_pkg::KIND_EXC;
      bundle.fin.exc_reason = ty_nxt;
    end else if (pos_r < didrp_pkg::POS_COUNT || fn_nxt != didrp_pkg::FC_DEVID ||
                 ty_nxt != didrp_pkg::MEI_DEVID) begin
      bundle.fin.kind = didrp_pkg::KIND_MALFORMED;
    end else if (complete_nxt == 8'd0) begin
      bundle.fin.kind = didrp_pkg::KIND_NONE;
    end else begin
      bundle.fin.kind         = didrp_pkg::KIND_DONE;
      bundle.fin.object_count = complete_nxt;
    end

    // end of frame: back to the reset state for the next response
    if (rx_eor) begin
      pos_nxt      = 4'd0;
      fn_nxt       = 8'd0;
      ty_nxt       = 8'd0;
      phase_nxt    = didrp_pkg::PH_ID;
      left_nxt     = 8'd0;
      id_nxt       = 8'd0;
      len_nxt      = 8'd0;
      vleft_nxt    = 8'd0;
      complete_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 4'd0;
      fn_r       <= 8'd0;
      ty_r       <= 8'd0;
      phase_r    <= didrp_pkg::PH_ID;
      left_r     <= 8'd0;
      id_r       <= 8'd0;
      len_r      <= 8'd0;
      vleft_r    <= 8'd0;
      complete_r <= 8'd0;
    end else if (acc) begin
      pos_r      <= pos_nxt;
      fn_r       <= fn_nxt;
      ty_r       <= ty_nxt;
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      vleft_r    <= vleft_nxt;
      complete_r <= complete_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= didrp_pkg::ENTRY_START)
    else $error("byte position past saturation");

  a_eor_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && rx_eor |=> pos_r == 4'd0 && complete_r == 8'd0)
    else $error("frame state not cleared after end of response");

  a_obj_counts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && bundle.mask[1] && !rx_eor |=> complete_r == $past(complete_r) + 8'd1)
    else $error("object complete without count update");
`endif

endmodule

`default_nettype wire

// ----- design/didrp_out_queue.sv -----
`default_nettype none

module didrp_out_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               acc,
  input  wire didrp_pkg::bundle_t bundle,
  output logic                    load_ok,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output didrp_pkg::res_t         out_res,
  output logic                    out_last
);

  logic [2:0]       mask_r;
  didrp_pkg::res_t  val_r;
  didrp_pkg::res_t  obj_r;
  didrp_pkg::res_t  fin_r;
  logic [2:0]       first;
  logic [2:0]       rest;
  logic             take;

  // oldest pending result is the lowest set bit
  assign first = mask_r[0] ? 3'b001 :
                 mask_r[1] ? 3'b010 :
                 mask_r[2] ? 3'b100 : 3'b000;
  assign rest  = mask_r & ~first;

  assign out_valid = |mask_r;
  assign out_last  = (rest == 3'b000);
  assign take      = out_valid && out_ready;
  assign load_ok   = !out_valid || (take && out_last);

  always_comb begin
    case (first)
      3'b001:  out_res = val_r;
      3'b010:  out_res = obj_r;
      default: out_res = fin_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'b000;
    end else if (acc) begin
      mask_r <= bundle.mask;
    end else if (take) begin
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      val_r <= bundle.val;
      obj_r <= bundle.obj;
      fin_r <= bundle.fin;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(mask_r))
    else $error("pending results changed while stalled");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_last && !acc |=> !out_valid)
    else $error("results remain after last of run");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(mask_r) > 1 |-> !load_ok)
    else $error("new request taken over pending results");
`endif

endmodule

`default_nettype wire

// ----- design/device_id_response_parser_top.sv -----
`default_nettype none

// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   response_byte[7:0], end_of_response
// out_ch   out  valid/ready   result_kind[2:0], object_id, object_length, data_byte,
//                             object_count, exc_reason, last_of_run
//
// One request per cycle while in_ch.ready is high; each yields 0..3 results, held
// in a result register and drained one per cycle while out_ch.ready is high.
// in_ch.ready is high when no result is pending, or the last pending one leaves now.
// A stall on out_ch holds the pending results and backs up in_ch; nothing is lost.
// Reset (rst_n low, synchronous) returns the parser to frame start and drops
// pending results. end_of_response also returns the parser to frame start.

module device_id_response_parser_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  didrp_in_if.sink   in_ch,
  didrp_out_if.source out_ch
);

  didrp_pkg::bundle_t bundle;
  didrp_pkg::res_t    out_res;
  logic               load_ok;
  logic               acc;

  // request accepted: parser state advances, results land in the queue
  assign acc         = in_ch.valid && load_ok;
  assign in_ch.ready = load_ok;

  // per-byte parse: header capture, entry walk, end-of-frame verdict
  didrp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_ch.response_byte),
    .rx_eor  (in_ch.end_of_response),
    .bundle  (bundle)
  );

  // result register: serializes value / object / final results in order
  didrp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .bundle    (bundle),
    .load_ok   (load_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .out_last  (out_ch.last_of_run)
  );

  assign out_ch.result_kind    = out_res.kind;
  assign out_ch.object_id      = out_res.object_id;
  assign out_ch.object_length  = out_res.object_length;
  assign out_ch.data_byte      = out_res.data_byte;
  assign out_ch.object_count   = out_res.object_count;
  assign out_ch.exc_reason     = out_res.exc_reason;

endmodule

`default_nettype wire
